[rtl/pad_chf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pad_chf_pkg
// Shared constants and types of the pad chord hold-back filter.
// ---------------------------------------------------------------------------
package pad_chf_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_CHORD_MASK   = 8'd0;
  localparam logic [7:0] REG_CHORD_WINDOW = 8'd1;
  localparam logic [7:0] REG_REPLAY_MS    = 8'd2;
  localparam logic [7:0] REG_DEADZONE     = 8'd3;

  // Reset values of the registers
  localparam logic [15:0] CHORD_MASK_RST   = 16'hC000;
  localparam logic [15:0] CHORD_WINDOW_RST = 16'd250;
  localparam logic [15:0] REPLAY_MS_RST    = 16'd120;
  localparam logic [14:0] DEADZONE_RST     = 15'd2048;

  // Stick scaling
  localparam logic [7:0] AXIS_CENTRE = 8'd128;
  localparam logic [7:0] AXIS_MAX    = 8'd255;
  localparam logic [7:0] TRIG_FULL   = 8'hFF;

  // Bus widths
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 120;
  localparam int CFG_IDX_W = 8;

  // One step request toward the chord filter
  typedef struct packed {
    logic        run;
    logic [15:0] buttons;
    logic [31:0] now;
  } pad_chf_step_t;

  // Chord filter settings
  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] window_ms;
    logic [15:0] replay_ms;
  } pad_chf_cfg_t;

endpackage

[rtl/pad_chf_axis.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pad_chf_axis
// Centers one raw stick byte, scales it to signed 16 bits and applies the
// deadzone. Pure combinational.
// ---------------------------------------------------------------------------
module pad_chf_axis (
  input  logic [7:0]         raw,
  input  logic [14:0]        deadzone,
  output logic signed [15:0] axis
);
  import pad_chf_pkg::*;

  logic [6:0]         mag;
  logic signed [16:0] scaled;
  logic signed [16:0] dz;

  // Above center: c * 32767 / 127 = 258 * c, plus one at full scale.
  // At or below center: c * 256, with c = raw - 128 sign-extended.
  always_comb begin
    mag = 7'(raw - AXIS_CENTRE);
    if (raw > AXIS_CENTRE) begin
      scaled = $signed({2'b00, mag, 8'b0}) + $signed({9'b0, mag, 1'b0})
               + $signed({16'b0, raw == AXIS_MAX});
    end else begin
      scaled = $signed({~raw[7], ~raw[7], raw[6:0], 8'b0});
    end
  end

  assign dz   = $signed({2'b00, deadzone});
  assign axis = ((scaled < dz) && (scaled > -dz)) ? 16'sd0 : scaled[15:0];

endmodule

[rtl/pad_chf_chord.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pad_chf_chord
// Chord hold-back state: chord latch and counter, lone-button window and
// tap replay. One step per sent reading.
// ---------------------------------------------------------------------------
module pad_chf_chord (
  input  logic                       clk,
  input  logic                       rst,
  input  pad_chf_pkg::pad_chf_step_t step,
  input  pad_chf_pkg::pad_chf_cfg_t  cfg,
  output logic [15:0]                buttons_out,
  output logic [15:0]                counter_next
);
  import pad_chf_pkg::*;

  logic        chord_down, chord_down_next;
  logic        chord_locked, chord_locked_next;
  logic [15:0] chord_counter;
  logic        pending_valid, pending_valid_next;
  logic [31:0] pending_start, pending_start_next;
  logic [15:0] replay_bits, replay_bits_next;
  logic [31:0] replay_end, replay_end_next;
  logic [15:0] withheld_bits;

  logic [15:0] held;
  logic [15:0] suppress;
  logic [31:0] start_eff;
  logic        in_window;
  logic [31:0] left;
  logic [15:0] replay_mid;

  // Window and chord decisions
  always_comb begin
    held               = step.buttons & cfg.mask;
    start_eff          = pending_valid ? pending_start : step.now;
    in_window          = (step.now - start_eff) < {16'b0, cfg.window_ms};
    chord_down_next    = chord_down;
    chord_locked_next  = chord_locked;
    counter_next       = chord_counter;
    pending_valid_next = pending_valid;
    pending_start_next = pending_start;
    replay_mid         = replay_bits;
    replay_end_next    = replay_end;
    suppress           = '0;
    if (step.run) begin
      chord_down_next = 1'b0;
      if (held == cfg.mask) begin
        if (!chord_down) counter_next = chord_counter + 16'd1;
        chord_down_next    = 1'b1;
        chord_locked_next  = 1'b1;
        suppress           = cfg.mask;
        pending_valid_next = 1'b0;
        replay_mid         = '0;
      end else if (chord_locked) begin
        suppress           = held;
        pending_valid_next = 1'b0;
        if (held == '0) chord_locked_next = 1'b0;
      end else if (held != '0) begin
        pending_start_next = start_eff;
        pending_valid_next = in_window;
        suppress           = in_window ? held : '0;
      end else begin
        // lone tap released inside the window: replay it
        if (pending_valid && in_window) begin
          replay_mid      = withheld_bits;
          replay_end_next = step.now + {16'b0, cfg.replay_ms};
        end
        pending_valid_next = 1'b0;
      end
    end
  end

  // Output buttons and replay expiry
  always_comb begin
    left             = replay_end_next - step.now;
    buttons_out      = step.buttons & ~suppress;
    replay_bits_next = replay_mid;
    if (replay_mid != '0) begin
      if ((left != '0) && !left[31]) begin
        buttons_out = buttons_out | replay_mid;
      end else begin
        replay_bits_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chord_down    <= 1'b0;
      chord_locked  <= 1'b0;
      chord_counter <= '0;
      pending_valid <= 1'b0;
      pending_start <= '0;
      replay_bits   <= '0;
      replay_end    <= '0;
      withheld_bits <= '0;
    end else if (step.run) begin
      chord_down    <= chord_down_next;
      chord_locked  <= chord_locked_next;
      chord_counter <= counter_next;
      pending_valid <= pending_valid_next;
      pending_start <= pending_start_next;
      replay_bits   <= replay_bits_next;
      replay_end    <= replay_end_next;
      withheld_bits <= suppress;
    end
  end

endmodule

[rtl/pad_chord_holdback_filter_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pad_chord_holdback_filter_top
// Controller poll filter: holds the last fresh reading, scales the sticks,
// holds back chord buttons and replays short taps.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  one poll (s_tdata, s_tuser)
// m_*       out        m_tvalid / m_tready  one reading (m_tdata, m_tuser)
// cfg_*     in         cfg_valid/cfg_ready  register index and data
//
// A request passes the input register, then the result register; one request
// per cycle is sustained while results are taken. The state update sits
// between the two registers in a single pass. A stalled result holds and the
// input register fills, after which s_tready drops. cfg_ready is always high.
// rst is synchronous; it clears control state and configuration, not data registers.
// ---------------------------------------------------------------------------
module pad_chord_holdback_filter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // raw_buttons, left_trigger_in, right_trigger_in, left_stick_x_raw,
  // left_stick_y_raw, right_stick_x_raw, right_stick_y_raw, now_ms
  input  logic [pad_chf_pkg::S_DATA_W-1:0]     s_tdata,
  // pad_present, fresh_report
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // buttons_out, left_trigger_out, right_trigger_out, left_x_out, left_y_out,
  // right_x_out, right_y_out, chord_completions, analog_trigger_seen, zero fill
  output logic [pad_chf_pkg::M_DATA_W-1:0]     m_tdata,
  // state_valid
  output logic                                 m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pad_chf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                          cfg_data
);
  import pad_chf_pkg::*;

  // configuration
  logic [15:0] chord_mask, chord_window_ms, replay_ms;
  logic [14:0] deadzone_level;

  // input register
  logic                s1_valid;
  logic [S_DATA_W-1:0] s1_data;
  logic [1:0]          s1_user;
  logic                advance;

  // held reading
  logic [15:0]        held_buttons, held_buttons_next;
  logic [7:0]         held_lt, held_lt_next, held_rt, held_rt_next;
  logic signed [15:0] held_axes [4];
  logic signed [15:0] axes_new [4];
  logic signed [15:0] axes_next [4];
  logic               have_reading, have_reading_next;
  logic               partial_seen, partial_seen_next;
  logic               fresh;

  pad_chf_step_t step;
  pad_chf_cfg_t  ccfg;
  logic [15:0]   chord_btn;
  logic [15:0]   counter_next;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chord_mask      <= CHORD_MASK_RST;
      chord_window_ms <= CHORD_WINDOW_RST;
      replay_ms       <= REPLAY_MS_RST;
      deadzone_level  <= DEADZONE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CHORD_MASK:   chord_mask      <= cfg_data;
        REG_CHORD_WINDOW: chord_window_ms <= cfg_data;
        REG_REPLAY_MS:    replay_ms       <= cfg_data;
        REG_DEADZONE:     deadzone_level  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // handshake: input register advances when the result slot frees up
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_data <= s_tdata;
      s1_user <= s_tuser;
    end
  end

  // stick scaling, one unit per axis
  for (genvar a = 0; a < 4; a++) begin : g_axis
    pad_chf_axis u_axis (
      .raw      (s1_data[32 + 8*a +: 8]),
      .deadzone (deadzone_level),
      .axis     (axes_new[a])
    );
  end

  // held reading update
  always_comb begin
    fresh             = s1_user[0] && s1_user[1];
    held_buttons_next = fresh ? s1_data[15:0] : held_buttons;
    held_lt_next      = fresh ? s1_data[23:16] : held_lt;
    held_rt_next      = fresh ? s1_data[31:24] : held_rt;
    for (int a = 0; a < 4; a++) begin
      axes_next[a] = fresh ? axes_new[a] : held_axes[a];
    end
    partial_seen_next = partial_seen
      || (fresh && (held_lt_next != '0) && (held_lt_next != TRIG_FULL))
      || (fresh && (held_rt_next != '0) && (held_rt_next != TRIG_FULL));
    have_reading_next = s1_user[0] && (s1_user[1] || have_reading);
  end

  assign step.run     = advance && have_reading_next;
  assign step.buttons = held_buttons_next;
  assign step.now     = s1_data[95:64];
  assign ccfg.mask      = chord_mask;
  assign ccfg.window_ms = chord_window_ms;
  assign ccfg.replay_ms = replay_ms;

  pad_chf_chord u_chord (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .cfg          (ccfg),
    .buttons_out  (chord_btn),
    .counter_next (counter_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons <= '0;
      held_lt      <= '0;
      held_rt      <= '0;
      have_reading <= 1'b0;
      partial_seen <= 1'b0;
      for (int a = 0; a < 4; a++) held_axes[a] <= '0;
    end else if (advance) begin
      held_buttons <= held_buttons_next;
      held_lt      <= held_lt_next;
      held_rt      <= held_rt_next;
      have_reading <= have_reading_next;
      partial_seen <= partial_seen_next;
      for (int a = 0; a < 4; a++) held_axes[a] <= axes_next[a];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= have_reading_next;
      if (have_reading_next) begin
        m_tdata[15:0]  <= chord_btn;
        m_tdata[23:16] <= held_lt_next;
        m_tdata[31:24] <= held_rt_next;
        m_tdata[47:32] <= axes_next[0];
        m_tdata[63:48] <= axes_next[1];
        m_tdata[79:64] <= axes_next[2];
        m_tdata[95:80] <= axes_next[3];
      end else begin
        m_tdata[95:0] <= '0;
      end
      m_tdata[111:96]  <= counter_next;
      m_tdata[112]     <= partial_seen_next;
      m_tdata[119:113] <= '0;
    end
  end

endmodule

[rtl/pad_chf_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pad_chf_checker
// Port-level checks of the filter, bound to the top level.
// ---------------------------------------------------------------------------
module pad_chf_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata,
  input logic         m_tuser
);
  logic seen_flag;

  // remember that the partial-trigger flag was reported
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_flag <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[112]) begin
      seen_flag <= 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[95:0] == 96'd0)
    else $error("reading fields nonzero with no reading sent");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_flag |-> m_tdata[112])
    else $error("partial trigger flag cleared");

endmodule

bind pad_chord_holdback_filter_top pad_chf_checker u_pad_chf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[test/tb_pad_chord_holdback_filter_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pad_chord_holdback_filter_top
// Self-checking bench for the pad chord hold-back filter. Polls are sent as
// stream requests; a scoreboard class tracks the held reading, stick scaling,
// chord latch, hold-back window and tap replay, and checks every reading
// field by field. A directed opener hits the corner cases; random phases
// sweep the register settings with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_pad_chord_holdback_filter_top;
  import pad_chf_pkg::*;

  localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
  localparam int LONG_HOLD    = 40;     // receiver hold-off for back-pressure
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 4;

  // Poll request payload, lowest field in the lowest bits
  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  ry;
    logic [7:0]  rx;
    logic [7:0]  ly;
    logic [7:0]  lx;
    logic [7:0]  rt;
    logic [7:0]  lt;
    logic [15:0] buttons;
  } poll_t;

  // Reading payload as it sits in m_tdata[112:0]
  typedef struct packed {
    logic               analog;
    logic [15:0]        count;
    logic signed [15:0] ry;
    logic signed [15:0] rx;
    logic signed [15:0] ly;
    logic signed [15:0] lx;
    logic [7:0]         rt;
    logic [7:0]         lt;
    logic [15:0]        buttons;
  } reading_t;

  typedef struct packed {
    logic     valid;
    reading_t rd;
  } expected_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predicts each reading from the accepted polls
  // -------------------------------------------------------------------------
  class chord_scoreboard;
    localparam int POS_FULL  = 32767;
    localparam int POS_SPAN  = 127;
    localparam int NEG_SCALE = 256;

    expected_t   readings_q[$];
    int          fails;
    // settings
    logic [15:0] mask;
    logic [15:0] window_ms;
    logic [15:0] replay_len;
    logic [14:0] deadzone;
    // filter state
    logic [15:0] held_buttons;
    logic [7:0]  held_lt, held_rt;
    logic [15:0] held_axes [4];
    logic        have_reading, partial_seen, chord_down, chord_locked;
    logic        pending_valid;
    logic [15:0] chord_count;
    logic [31:0] pending_start;
    logic [15:0] replay_bits;
    logic [31:0] replay_end;
    logic [15:0] withheld;

    function new();
      fails = 0;
      mask = CHORD_MASK_RST;
      window_ms = CHORD_WINDOW_RST;
      replay_len = REPLAY_MS_RST;
      deadzone = DEADZONE_RST;
      held_buttons = '0;
      held_lt = '0;
      held_rt = '0;
      foreach (held_axes[k]) held_axes[k] = '0;
      have_reading = 0;
      partial_seen = 0;
      chord_down = 0;
      chord_locked = 0;
      pending_valid = 0;
      chord_count = '0;
      pending_start = '0;
      replay_bits = '0;
      replay_end = '0;
      withheld = '0;
    endfunction

    function int pending();
      return readings_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_CHORD_MASK:   mask = data;
        REG_CHORD_WINDOW: window_ms = data;
        REG_REPLAY_MS:    replay_len = data;
        REG_DEADZONE:     deadzone = data[14:0];
        default: ;
      endcase
    endfunction

    // Centre at 128, asymmetric scale, deadzone to zero
    function logic [15:0] scale_stick(logic [7:0] raw);
      int c, r, dz;
      c = int'(raw) - int'(AXIS_CENTRE);
      dz = int'(deadzone);
      if (c > 0) r = (c * POS_FULL) / POS_SPAN;
      else r = c * NEG_SCALE;
      if (r > -dz && r < dz) r = 0;
      return r[15:0];
    endfunction

    function void note_poll(logic [1:0] user, logic [S_DATA_W-1:0] data);
      poll_t       p;
      expected_t   e;
      logic [15:0] held, suppress, btn;
      logic [31:0] elapsed, left;
      p = data;
      e = '0;
      suppress = '0;

      // refresh the held reading
      if (!user[0]) begin
        have_reading = 0;
      end else if (user[1]) begin
        held_buttons = p.buttons;
        held_lt = p.lt;
        held_rt = p.rt;
        if ((p.lt != 0 && p.lt != TRIG_FULL) || (p.rt != 0 && p.rt != TRIG_FULL))
          partial_seen = 1;
        held_axes[0] = scale_stick(p.lx);
        held_axes[1] = scale_stick(p.ly);
        held_axes[2] = scale_stick(p.rx);
        held_axes[3] = scale_stick(p.ry);
        have_reading = 1;
      end

      // chord filter
      if (have_reading) begin
        held = held_buttons & mask;
        if (held == mask) begin
          if (!chord_down) chord_count = chord_count + 16'd1;
          chord_down = 1;
          chord_locked = 1;
          suppress = mask;
          pending_valid = 0;
          replay_bits = '0;
        end else if (chord_locked) begin
          chord_down = 0;
          suppress = held;
          pending_valid = 0;
          if (held == 0) chord_locked = 0;
        end else begin
          chord_down = 0;
          if (held != 0) begin
            if (!pending_valid) begin
              pending_valid = 1;
              pending_start = p.now;
            end
            elapsed = p.now - pending_start;
            if (elapsed < {16'h0, window_ms}) suppress = held;
            else pending_valid = 0;
          end else begin
            elapsed = p.now - pending_start;
            if (pending_valid && elapsed < {16'h0, window_ms}) begin
              replay_bits = withheld;
              replay_end = p.now + {16'h0, replay_len};
            end
            pending_valid = 0;
          end
        end
        withheld = suppress;

        btn = held_buttons & ~suppress;
        if (replay_bits != 0) begin
          left = replay_end - p.now;
          if (left != 0 && !left[31]) btn = btn | replay_bits;
          else replay_bits = '0;
        end

        e.valid = 1;
        e.rd.buttons = btn;
        e.rd.lt = held_lt;
        e.rd.rt = held_rt;
        e.rd.lx = held_axes[0];
        e.rd.ly = held_axes[1];
        e.rd.rx = held_axes[2];
        e.rd.ry = held_axes[3];
      end
      e.rd.count = chord_count;
      e.rd.analog = partial_seen;
      readings_q.push_back(e);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t mismatch %s: expected %0d got %0d", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_reading(logic [M_DATA_W-1:0] data, logic user);
      expected_t e;
      reading_t  a;
      if (readings_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t unexpected reading %h", $realtime, data);
        return;
      end
      e = readings_q.pop_front();
      a = data[$bits(reading_t)-1:0];
      compare_field("state_valid", e.valid, user);
      compare_field("buttons_out", e.rd.buttons, a.buttons);
      compare_field("left_trigger_out", e.rd.lt, a.lt);
      compare_field("right_trigger_out", e.rd.rt, a.rt);
      compare_field("left_x_out", e.rd.lx, a.lx);
      compare_field("left_y_out", e.rd.ly, a.ly);
      compare_field("right_x_out", e.rd.rx, a.rx);
      compare_field("right_y_out", e.rd.ry, a.ry);
      compare_field("chord_completions", e.rd.count, a.count);
      compare_field("analog_trigger_seen", e.rd.analog, a.analog);
      compare_field("fill", 0, int'(data[M_DATA_W-1:$bits(reading_t)]));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and signals
  // -------------------------------------------------------------------------
  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [1:0]            s_tuser = '0;   // pad_present, fresh_report
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  chord_scoreboard sb = new();
  int          quiet_cycles = 0;
  logic        long_hold = 0;    // receiver back-pressure request
  logic        no_idle = 0;      // final stretch without idling
  logic [15:0] cur_mask = CHORD_MASK_RST;
  logic [31:0] cur_now = '0;

  pad_chord_holdback_filter_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Monitor: check readings, note polls and register writes at the edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_reading(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_poll(s_tuser, s_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // -------------------------------------------------------------------------
  initial begin : receiver
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 0;
        m_tready <= 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        m_tready <= 1;
      end else begin
        m_tready <= 1;
      end
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks, all entered and left at a falling edge
  // -------------------------------------------------------------------------
  function automatic logic [S_DATA_W-1:0] make_poll(logic [15:0] buttons, logic [7:0] lt,
                                                    logic [7:0] rt, logic [7:0] lx,
                                                    logic [7:0] ly, logic [7:0] rx,
                                                    logic [7:0] ry, logic [31:0] now);
    poll_t p;
    p = '{now: now, ry: ry, rx: rx, ly: ly, lx: lx, rt: rt, lt: lt, buttons: buttons};
    return p;
  endfunction

  task automatic send_poll(logic present, logic fresh, logic [S_DATA_W-1:0] data);
    s_tvalid <= 1;
    s_tdata <= data;
    s_tuser <= {fresh, present};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!no_idle && !long_hold && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Wait for every reading, then let the pipe drain before a register write
  task automatic settle();
    s_tvalid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CHORD_MASK) cur_mask = data;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic set_all(logic [15:0] mask, logic [15:0] win, logic [15:0] rep,
                         logic [15:0] dz);
    write_cfg(REG_CHORD_MASK, mask);
    write_cfg(REG_CHORD_WINDOW, win);
    write_cfg(REG_REPLAY_MS, rep);
    write_cfg(REG_DEADZONE, dz);
  endtask

  function automatic logic [7:0] pick_trigger();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return TRIG_FULL;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_stick();
    if ($urandom_range(0, 3) == 0) return 8'(int'(AXIS_CENTRE) + $urandom_range(0, 16) - 8);
    return 8'($urandom);
  endfunction

  // Mostly chord play against the current mask, with random timing
  task automatic run_random(int count);
    logic [15:0] chord_bits, other_bits;
    logic        present, fresh;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: chord_bits = '0;
        4, 5, 6:    chord_bits = cur_mask & 16'($urandom);
        default:    chord_bits = cur_mask;
      endcase
      other_bits = ($urandom_range(0, 1) == 0) ? '0 : (16'($urandom) & ~cur_mask);
      if ($urandom_range(0, 9) == 0) chord_bits = 16'($urandom);
      case ($urandom_range(0, 19))
        0:       cur_now = $urandom;
        1, 2, 3: cur_now = cur_now + $urandom_range(0, 600);
        default: cur_now = cur_now + $urandom_range(0, 60);
      endcase
      present = ($urandom_range(0, 19) != 0);
      fresh = ($urandom_range(0, 6) != 0);
      send_poll(present, fresh,
                make_poll(chord_bits | other_bits, pick_trigger(), pick_trigger(),
                          pick_stick(), pick_stick(), pick_stick(), pick_stick(), cur_now));
      maybe_gap();
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: nothing sent before any reading
    send_poll(0, 1, make_poll(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0));
    send_poll(1, 0, make_poll(16'hFFFF, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0));
    // stick and trigger extremes, at rest and just off centre inside the deadzone
    send_poll(1, 1, make_poll(16'h0000, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 32'd0));
    send_poll(1, 1, make_poll(16'h0000, 8'h01, 8'hFE, 8'h01, 8'h81, 8'h82, 8'h7E, 32'd10));
    // lone tap inside the window, replayed after release until it runs out
    send_poll(1, 1, make_poll(16'h4000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd20));
    send_poll(1, 1, make_poll(16'h0000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd50));
    send_poll(1, 0, make_poll(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd100));
    send_poll(1, 0, make_poll(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd170));
    // full chord counted once, latched until both buttons are up
    send_poll(1, 1, make_poll(16'hC000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd200));
    send_poll(1, 1, make_poll(16'hC000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd210));
    send_poll(1, 1, make_poll(16'h8000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd220));
    send_poll(1, 1, make_poll(16'h0000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd230));
    // lone button held past the window passes through
    send_poll(1, 1, make_poll(16'h8000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd300));
    send_poll(1, 1, make_poll(16'h8000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd600));
    send_poll(1, 1, make_poll(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 32'd610));
    send_poll(1, 1, make_poll(16'h3FFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 32'd620));
    // pad absent drops the reading; stale poll then sends nothing
    send_poll(0, 0, make_poll(16'h0000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd630));
    send_poll(1, 0, make_poll(16'h4000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd640));
    // hold-back and replay across the time wrap, pending start at time zero
    send_poll(1, 1, make_poll(16'h4000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
                              32'hFFFF_FFF0));
    send_poll(1, 1, make_poll(16'h0000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
                              32'h0000_0010));
    send_poll(1, 1, make_poll(16'h8000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd0));
    send_poll(1, 1, make_poll(16'h0000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 32'd0));
    send_poll(1, 0, make_poll(16'h0000, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80,
                              32'hFFFF_FFFF));
    cur_now = 32'd1000;

    run_random(120);

    // empty chord mask and the widest settings, with the long hold-off
    settle();
    set_all(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    long_hold = 1;
    run_random(130);

    // every button in the chord, zero window, replay and deadzone
    settle();
    set_all(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    run_random(130);

    // single-button chord, short timing; stray register indexes are ignored
    settle();
    set_all(16'h0001, 16'd30, 16'd10, 16'd1);
    write_cfg(CFG_IDX_W'(4), 16'h1234);
    write_cfg({CFG_IDX_W{1'b1}}, 16'hFFFF);
    long_hold = 1;
    run_random(130);

    // random two-button chord and random timing
    settle();
    set_all(16'(1 << $urandom_range(0, 7)) | 16'(1 << $urandom_range(8, 15)),
            16'($urandom_range(1, 500)), 16'($urandom_range(1, 300)), 16'($urandom));
    run_random(130);

    // back to the power-on settings, final stretch without idling
    settle();
    set_all(CHORD_MASK_RST, CHORD_WINDOW_RST, REPLAY_MS_RST, 16'(DEADZONE_RST));
    run_random(60);
    no_idle = 1;
    run_random(100);

    s_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
